// ===== rtl/uwo_pkg.sv =====
package uwo_pkg;

   // Table geometry and voice count.
   localparam int TABLE_BITS = 11;
   localparam int TABLE_LEN = 1 << TABLE_BITS;
   localparam int FRAC_BITS = 32 - TABLE_BITS;
   localparam int VOICES = 6;
   localparam int NUM_INC_REGS = 6;
   localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

   // Field and register widths.
   localparam int PHASE_W = 32;
   localparam int SAMPLE_W = 16;
   localparam int WAVE_W = 2;
   localparam int VCNT_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W = 3;

   // Accumulator: one voice value is SAMPLE_W + FRAC_BITS bits, up to six are summed.
   localparam int VSUM_BITS = 3;
   localparam int ACC_W = SAMPLE_W + FRAC_BITS + VSUM_BITS;
   localparam int DIFF_W = SAMPLE_W + 1;

   // Averaging divider: four quotient bits per cycle.
   localparam int SUMQ_W = ACC_W - FRAC_BITS;
   localparam int DIV_STEPS = 4;
   localparam int DIVD_W = ((SUMQ_W + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
   localparam int DIV_CYCLES = DIVD_W / DIV_STEPS;
   localparam int DIV_CNT_W = $clog2(DIV_CYCLES + 1);
   localparam int BIAS_SHIFT = SAMPLE_W - 1;

   // Sine builder arithmetic, Q30 values.
   localparam int SIN_W = 31;
   localparam int SIN_FRAC = 30;
   localparam logic [SIN_W-1:0] SIN_C1 = SIN_W'(1686629713);
   localparam logic [SIN_W-1:0] SIN_C3 = SIN_W'(693598669);
   localparam logic [SIN_W-1:0] SIN_C5 = SIN_W'(85569306);
   localparam logic [SIN_W-1:0] SIN_C7 = SIN_W'(5026995);
   localparam logic [SIN_W-1:0] SIN_C9 = SIN_W'(172272);
   localparam logic [SIN_W-1:0] SINE_AMP = SIN_W'(32767);
   localparam logic [1:0] COEF_LAST = 2'd3;

   // Sample limits.
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7fff;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;
   localparam logic [SAMPLE_W-1:0] SIGN_FLIP = 16'h8000;

   // Waveform codes.
   localparam logic [WAVE_W-1:0] WAVE_SAW = 2'd0;
   localparam logic [WAVE_W-1:0] WAVE_SQUARE = 2'd1;

   // Register indexes.
   localparam logic [REG_IDX_W-1:0] REG_WAVEFORM = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_VOICE_COUNT = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_INC0 = 3'd2;

   typedef logic [VOICES-1:0][PHASE_W-1:0] voice_word_type;

   // Table builder operations.
   typedef enum logic [3:0] {
      BOP_IDLE = 4'd0,
      BOP_LOAD_X = 4'd1,
      BOP_SQUARE = 4'd2,
      BOP_SAVE_X2 = 4'd3,
      BOP_MUL_X2 = 4'd4,
      BOP_COEF = 4'd5,
      BOP_MUL_X = 4'd6,
      BOP_SCALE = 4'd7,
      BOP_WRITE = 4'd8
   } bld_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic issue;
      logic [VIDX_W-1:0] voice;
      logic div_start;
      logic load_out;
      logic bld_clear;
      bld_op_type bld_op;
      logic [1:0] coef_sel;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic bld_last;
      logic bld_sine;
      logic pipe_busy;
      logic div_done;
      logic out_free;
   } stat_type;

   // Active voice count: zero acts as one, values above VOICES act as VOICES.
   function automatic logic [VCNT_W-1:0] clamp_voices(input logic [VCNT_W-1:0] vc);
      logic [VCNT_W-1:0] r;
      if (vc == '0) begin
         r = VCNT_W'(1);
      end else if (vc > VCNT_W'(VOICES)) begin
         r = VCNT_W'(VOICES);
      end else begin
         r = vc;
      end
      return r;
   endfunction

   // Horner coefficients after the first one, from x^7 down to x^1.
   function automatic logic [SIN_W-1:0] sin_coef(input logic [1:0] sel);
      logic [SIN_W-1:0] c;
      case (sel)
         2'd0: c = SIN_C7;
         2'd1: c = SIN_C5;
         2'd2: c = SIN_C3;
         default: c = SIN_C1;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/uwo_div.sv =====
module uwo_div (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [uwo_pkg::DIVD_W-1:0] dividend,
   input  logic [uwo_pkg::VCNT_W-1:0] divisor,
   output logic [uwo_pkg::DIVD_W-1:0] quotient,
   output logic done
);
   import uwo_pkg::*;

   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [VCNT_W-1:0] rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic busy_ff;

   // Restoring division, several quotient bits per cycle on a narrow remainder.
   always_comb begin
      logic [VCNT_W:0] trial;
      quo_in = quo_ff;
      rem_in = rem_ff;
      for (int k = 0; k < DIV_STEPS; k++) begin
         trial = {rem_in, quo_in[DIVD_W-1]};
         quo_in = {quo_in[DIVD_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
            quo_in[0] = 1'b1;
         end
         rem_in = trial[VCNT_W-1:0];
      end
   end

   // Control: count the iterations of one division.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff <= DIV_CNT_W'(DIV_CYCLES);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Dividend shifts out at the top while quotient bits enter at the bottom.
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient = quo_ff;
   assign done = !busy_ff;

endmodule

// ===== rtl/uwo_dp.sv =====
module uwo_dp (
   input  logic clock,
   input  logic reset,
   input  uwo_pkg::cmd_type cmd,
   output uwo_pkg::stat_type stat,
   input  logic restart,
   input  logic [uwo_pkg::WAVE_W-1:0] waveform,
   input  logic [uwo_pkg::VCNT_W-1:0] active,
   input  uwo_pkg::voice_word_type inc,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [uwo_pkg::SAMPLE_W-1:0] rsp_tdata
);
   import uwo_pkg::*;

   // Wavetable memory and read data.
   logic signed [SAMPLE_W-1:0] wave_mem [TABLE_LEN];
   logic signed [SAMPLE_W-1:0] rd0_ff, rd1_ff;

   // Table builder.
   logic [TABLE_BITS-1:0] bld_idx_ff;
   logic [1:0] quad;
   logic [TABLE_BITS-3:0] qrem;
   logic [TABLE_BITS-2:0] qpos;
   logic [SIN_W-1:0] xval;
   logic [SIN_W-1:0] bx_ff, bx2_ff, bp_ff;
   logic neg_ff;
   logic [2*SIN_W-1:0] bprod_ff, bprod_in, rnd;
   logic [SIN_W-1:0] bprod_hi, mul_a, mul_b;
   logic [2*SIN_W-SIN_FRAC-1:0] sine_wide;
   logic [SAMPLE_W-1:0] sine_mag, sine_val, saw_val, square_val, table_val;

   // Voice pipeline.
   voice_word_type phase_ff;
   logic [PHASE_W-1:0] cur_phase;
   logic [TABLE_BITS-1:0] rd_idx0, rd_idx1;
   logic [FRAC_BITS-1:0] frac_ff;
   logic s1_valid_ff, s2_valid_ff;
   logic signed [DIFF_W-1:0] diff;
   logic signed [DIFF_W+FRAC_BITS:0] vprod_in, vprod_ff;
   logic signed [ACC_W-1:0] base_in, base_ff, acc_ff;

   // Averaging and output.
   logic signed [SUMQ_W-1:0] sum_q;
   logic [DIVD_W-1:0] div_dividend, div_quo;
   logic div_done;
   logic [SAMPLE_W-1:0] sample;
   logic rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_data_ff;

   // Quarter-wave position of the entry being built, mirrored in odd quarters.
   assign quad = bld_idx_ff[TABLE_BITS-1:TABLE_BITS-2];
   assign qrem = bld_idx_ff[TABLE_BITS-3:0];
   assign qpos = quad[0] ? ((TABLE_BITS-1)'(TABLE_LEN / 4) - (TABLE_BITS-1)'(qrem))
                         : (TABLE_BITS-1)'(qrem);
   assign xval = SIN_W'(qpos) << (32 - TABLE_BITS);
   assign bprod_hi = bprod_ff[SIN_W+SIN_FRAC-1:SIN_FRAC];

   // Shared builder multiplier operands.
   always_comb begin
      case (cmd.bld_op)
         BOP_SQUARE: begin
            mul_a = bx_ff;
            mul_b = bx_ff;
         end
         BOP_MUL_X2: begin
            mul_a = bp_ff;
            mul_b = bx2_ff;
         end
         BOP_MUL_X: begin
            mul_a = bp_ff;
            mul_b = bx_ff;
         end
         BOP_SCALE: begin
            mul_a = bprod_hi;
            mul_b = SINE_AMP;
         end
         default: begin
            mul_a = bx_ff;
            mul_b = bx_ff;
         end
      endcase
   end

   assign bprod_in = (2*SIN_W)'(mul_a) * (2*SIN_W)'(mul_b);

   // Builder registers, one polynomial step per cycle.
   always_ff @(posedge clock) begin
      case (cmd.bld_op)
         BOP_LOAD_X: begin
            bx_ff <= xval;
            neg_ff <= quad[1];
         end
         BOP_SQUARE, BOP_MUL_X2, BOP_MUL_X, BOP_SCALE: begin
            bprod_ff <= bprod_in;
         end
         BOP_SAVE_X2: begin
            bx2_ff <= bprod_hi;
            bp_ff <= SIN_C9;
         end
         BOP_COEF: begin
            bp_ff <= sin_coef(cmd.coef_sel) - bprod_hi;
         end
         default: begin
         end
      endcase
   end

   // Entry value for the selected shape.
   assign rnd = bprod_ff + ((2*SIN_W)'(1) << (SIN_FRAC - 1));
   assign sine_wide = rnd[2*SIN_W-1:SIN_FRAC];
   assign sine_mag = (sine_wide > (2*SIN_W-SIN_FRAC)'(SAMPLE_MAX)) ? SAMPLE_MAX
                                                                  : sine_wide[SAMPLE_W-1:0];
   assign sine_val = neg_ff ? (SAMPLE_W'(0) - sine_mag) : sine_mag;
   assign saw_val = SAMPLE_W'({bld_idx_ff, {(SAMPLE_W-TABLE_BITS){1'b0}}}) ^ SIGN_FLIP;
   assign square_val = bld_idx_ff[TABLE_BITS-1] ? SAMPLE_MIN : SAMPLE_MAX;

   always_comb begin
      case (waveform)
         WAVE_SAW: table_val = saw_val;
         WAVE_SQUARE: table_val = square_val;
         default: table_val = sine_val;
      endcase
   end

   // Build index sweeps the table once per rebuild.
   always_ff @(posedge clock) begin
      if (reset) begin
         bld_idx_ff <= '0;
      end else if (cmd.bld_clear) begin
         bld_idx_ff <= '0;
      end else if (cmd.bld_op == BOP_WRITE) begin
         bld_idx_ff <= bld_idx_ff + TABLE_BITS'(1);
      end
   end

   // Table read addresses of the issued voice; the upper neighbor wraps to entry 0.
   assign cur_phase = phase_ff[cmd.voice];
   assign rd_idx0 = cur_phase[PHASE_W-1:FRAC_BITS];
   assign rd_idx1 = rd_idx0 + TABLE_BITS'(1);

   // Wavetable: one write port for the builder, two registered read ports.
   always_ff @(posedge clock) begin
      if (cmd.bld_op == BOP_WRITE) begin
         wave_mem[bld_idx_ff] <= table_val;
      end
      if (cmd.issue) begin
         rd0_ff <= wave_mem[rd_idx0];
         rd1_ff <= wave_mem[rd_idx1];
         frac_ff <= cur_phase[FRAC_BITS-1:0];
      end
   end

   // Voice phases: cleared by restart, advanced when the voice is issued.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (cmd.accept && restart) begin
         phase_ff <= '0;
      end else if (cmd.issue) begin
         phase_ff[cmd.voice] <= cur_phase + inc[cmd.voice];
      end
   end

   // Interpolation as t0 * 2^F + (t1 - t0) * frac.
   assign diff = DIFF_W'(rd1_ff) - DIFF_W'(rd0_ff);
   assign vprod_in = diff * $signed({1'b0, frac_ff});
   assign base_in = ACC_W'(rd0_ff) <<< FRAC_BITS;

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         vprod_ff <= vprod_in;
         base_ff <= base_in;
      end
      if (cmd.accept) begin
         acc_ff <= '0;
      end else if (s2_valid_ff) begin
         acc_ff <= acc_ff + base_ff + ACC_W'(vprod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Floor of the sum over 2^F, biased positive for the unsigned divider.
   assign sum_q = acc_ff[ACC_W-1:FRAC_BITS];
   assign div_dividend = DIVD_W'(sum_q) + (DIVD_W'(active) << BIAS_SHIFT);

   uwo_div u_div (
      .clock(clock),
      .reset(reset),
      .start(cmd.div_start),
      .dividend(div_dividend),
      .divisor(active),
      .quotient(div_quo),
      .done(div_done)
   );

   // Remove the bias and clamp to the sample range.
   assign sample = (div_quo > DIVD_W'({SAMPLE_W{1'b1}})) ? SAMPLE_MAX
                                                         : (div_quo[SAMPLE_W-1:0] ^ SIGN_FLIP);

   // Output register parts the result from the next item's work.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= sample;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   always_comb begin
      stat.bld_last = (bld_idx_ff == TABLE_BITS'(TABLE_LEN - 1));
      stat.bld_sine = waveform[1];
      stat.pipe_busy = s1_valid_ff | s2_valid_ff;
      stat.div_done = div_done;
      stat.out_free = !rsp_valid_ff || rsp_tready;
   end

endmodule

// ===== rtl/uwo_ctrl.sv =====
module uwo_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic rebuild,
   input  logic [uwo_pkg::VCNT_W-1:0] active,
   input  uwo_pkg::stat_type stat,
   output uwo_pkg::cmd_type cmd
);
   import uwo_pkg::*;

   typedef enum logic [12:0] {
      ST_IDLE = 13'b0000000000001,
      ST_ISSUE = 13'b0000000000010,
      ST_DRAIN = 13'b0000000000100,
      ST_DIVIDE = 13'b0000000001000,
      ST_FINISH = 13'b0000000010000,
      ST_BX = 13'b0000000100000,
      ST_BSQ = 13'b0000001000000,
      ST_BX2 = 13'b0000010000000,
      ST_BMUL = 13'b0000100000000,
      ST_BCOEF = 13'b0001000000000,
      ST_BMULX = 13'b0010000000000,
      ST_BSCALE = 13'b0100000000000,
      ST_BWRITE = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic [VIDX_W-1:0] vidx_ff, vidx_in;
   logic [1:0] coef_ff, coef_in;

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      vidx_in = vidx_ff;
      coef_in = coef_ff;
      req_tready = 1'b0;
      cmd = '0;
      cmd.bld_op = BOP_IDLE;
      cmd.voice = vidx_ff;
      cmd.coef_sel = coef_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               vidx_in = '0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            if (VCNT_W'(vidx_ff) == active - VCNT_W'(1)) begin
               state_in = ST_DRAIN;
            end else begin
               vidx_in = vidx_ff + VIDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) begin
               cmd.div_start = 1'b1;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (stat.div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_BX: begin
            cmd.bld_op = BOP_LOAD_X;
            state_in = stat.bld_sine ? ST_BSQ : ST_BWRITE;
         end
         ST_BSQ: begin
            cmd.bld_op = BOP_SQUARE;
            state_in = ST_BX2;
         end
         ST_BX2: begin
            cmd.bld_op = BOP_SAVE_X2;
            coef_in = '0;
            state_in = ST_BMUL;
         end
         ST_BMUL: begin
            cmd.bld_op = BOP_MUL_X2;
            state_in = ST_BCOEF;
         end
         ST_BCOEF: begin
            cmd.bld_op = BOP_COEF;
            if (coef_ff == COEF_LAST) begin
               state_in = ST_BMULX;
            end else begin
               coef_in = coef_ff + 2'd1;
               state_in = ST_BMUL;
            end
         end
         ST_BMULX: begin
            cmd.bld_op = BOP_MUL_X;
            state_in = ST_BSCALE;
         end
         ST_BSCALE: begin
            cmd.bld_op = BOP_SCALE;
            state_in = ST_BWRITE;
         end
         ST_BWRITE: begin
            cmd.bld_op = BOP_WRITE;
            state_in = stat.bld_last ? ST_IDLE : ST_BX;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A waveform write restarts the table sweep and holds off new transactions.
      if (rebuild) begin
         req_tready = 1'b0;
         cmd.accept = 1'b0;
         cmd.bld_op = BOP_IDLE;
         cmd.bld_clear = 1'b1;
         state_in = ST_BX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BX;
         vidx_ff <= '0;
         coef_ff <= '0;
      end else begin
         state_ff <= state_in;
         vidx_ff <= vidx_in;
         coef_ff <= coef_in;
      end
   end

endmodule

// ===== rtl/unison_wavetable_oscillator.sv =====
// Unison wavetable oscillator. Each req transaction is one sample tick and normally yields one
// rsp transaction carrying a signed Q1.15 sample: the floored average of up to six voices, each
// reading a 2048-entry table with linear interpolation and then advancing its 32-bit phase by
// its own increment register. A set restart bit zeroes all phases before the sample is made.
// A waveform write abandons a tick whose sample is not yet loaded. The voices pass one per cycle
// through the table read port and the interpolation multiplier, then the averaging divider works
// out four quotient bits per iteration. A finished sample waits in an output register, so the
// next tick is accepted while it is still pending. After reset and after every write to the
// waveform register, the table is rebuilt in a sweep and no tick is accepted meanwhile; a saw or
// square entry is written directly, a sine entry is worked out by Horner steps on a shared
// multiplier. Registers sit at byte addresses 0 (waveform), 4 (voice count) and 8 to 28 (voice
// increments 0 to 5); writes take effect at the access phase, pready is always high.
module unison_wavetable_oscillator (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,        // [0] restart, [7:1] zero
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [15:0] rsp_tdata,       // [15:0] sample
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [uwo_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [uwo_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [uwo_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);
   import uwo_pkg::*;

   logic [WAVE_W-1:0] waveform_ff;
   logic [VCNT_W-1:0] voice_count_ff;
   logic [NUM_INC_REGS-1:0][PHASE_W-1:0] inc_ff;
   logic [REG_IDX_W-1:0] reg_idx, inc_sel;
   logic wr_en, rebuild;
   logic [VCNT_W-1:0] active;
   voice_word_type dp_inc;
   cmd_type cmd;
   stat_type stat;

   // Register decode; the low address bits are ignored.
   assign reg_idx = csr_paddr[CSR_ADDR_W-1:2];
   assign inc_sel = reg_idx - REG_INC0;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign rebuild = wr_en && (reg_idx == REG_WAVEFORM);
   assign csr_pready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         waveform_ff <= WAVE_SAW;
         voice_count_ff <= VCNT_W'(1);
         inc_ff <= '0;
      end else if (wr_en) begin
         case (reg_idx)
            REG_WAVEFORM: waveform_ff <= csr_pwdata[WAVE_W-1:0];
            REG_VOICE_COUNT: voice_count_ff <= csr_pwdata[VCNT_W-1:0];
            default: inc_ff[inc_sel] <= csr_pwdata;
         endcase
      end
   end

   // Register readback.
   always_comb begin
      case (reg_idx)
         REG_WAVEFORM: csr_prdata = CSR_DATA_W'(waveform_ff);
         REG_VOICE_COUNT: csr_prdata = CSR_DATA_W'(voice_count_ff);
         default: csr_prdata = inc_ff[inc_sel];
      endcase
   end

   // Increments of the voices that exist in hardware.
   always_comb begin
      for (int v = 0; v < VOICES; v++) begin
         dp_inc[v] = inc_ff[v];
      end
   end

   assign active = clamp_voices(voice_count_ff);

   uwo_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rebuild(rebuild),
      .active(active),
      .stat(stat),
      .cmd(cmd)
   );

   uwo_dp u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .stat(stat),
      .restart(req_tdata[0]),
      .waveform(waveform_ff),
      .active(active),
      .inc(dp_inc),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

endmodule
